FILE: design/sdiv4_pkg.sv
// Shared types and constants for the four-mode signed divider.
package sdiv4_pkg;

    localparam int DATA_WIDTH = 32;

    // Rounding mode codes
    localparam logic [1:0] MODE_TRUNC = 2'd0;
    localparam logic [1:0] MODE_FLOOR = 2'd1;
    localparam logic [1:0] MODE_CEIL  = 2'd2;
    localparam logic [1:0] MODE_ROUND = 2'd3;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] divisor;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        logic signed [DATA_WIDTH-1:0] remainder;
        logic                         divide_by_zero;
        logic                         overflow;
    } t_out_item;

    // Per-item side information carried alongside the magnitudes
    typedef struct packed {
        logic [1:0] mode;
        logic       sx;
        logic       sy;
        logic       dz;
        logic       ovf;
    } t_side;

    // Data handed from cell to cell: partial remainder, dividend bits
    // shifting out at the top and quotient bits shifting in at the bottom
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] acc;
        logic [DATA_WIDTH-1:0] ay;
        t_side                 side;
    } t_stage;

    // After rounding, before the sign is put back
    typedef struct packed {
        logic [DATA_WIDTH-1:0] qm;
        logic [DATA_WIDTH-1:0] rm;
        logic                  qneg;
        t_side                 side;
    } t_rnd;

endpackage

FILE: design/sdiv4_front.sv
// Input stage: magnitudes, signs and special-case flags.
module sdiv4_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  sdiv4_pkg::t_in_item   i_item,
    output logic                  o_valid,
    output sdiv4_pkg::t_stage     o_data
);
    localparam int W = sdiv4_pkg::DATA_WIDTH;

    logic             r_valid;
    sdiv4_pkg::t_stage r_data;
    sdiv4_pkg::t_stage n_data;
    logic [W-1:0]     x_u;
    logic [W-1:0]     y_u;
    logic [W-1:0]     min_val;

    always_comb begin
        x_u     = $unsigned(i_item.dividend);
        y_u     = $unsigned(i_item.divisor);
        min_val = {1'b1, {(W-1){1'b0}}};
        n_data.rem       = '0;
        n_data.acc       = x_u[W-1] ? (~x_u + 1'b1) : x_u;
        n_data.ay        = y_u[W-1] ? (~y_u + 1'b1) : y_u;
        n_data.side.mode = i_item.mode;
        n_data.side.sx   = x_u[W-1];
        n_data.side.sy   = y_u[W-1];
        n_data.side.dz   = (y_u == '0);
        n_data.side.ovf  = (x_u == min_val) && (y_u == {W{1'b1}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/sdiv4_cell.sv
// One restoring division step: yields one quotient bit.
module sdiv4_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  sdiv4_pkg::t_stage i_data,
    output logic              o_valid,
    output sdiv4_pkg::t_stage o_data
);
    localparam int W = sdiv4_pkg::DATA_WIDTH;

    logic              r_valid;
    sdiv4_pkg::t_stage r_data;
    sdiv4_pkg::t_stage n_data;
    logic [W-1:0]      shifted;
    logic [W:0]        diff;
    logic              ge;

    // For a nonzero divisor the partial remainder stays below the divisor magnitude, so its top bit
    // is always clear and the shift fits in W bits.
    always_comb begin
        shifted     = {i_data.rem[W-2:0], i_data.acc[W-1]};
        diff        = {1'b0, shifted} - {1'b0, i_data.ay};
        ge          = ~diff[W];
        n_data      = i_data;
        n_data.rem  = ge ? diff[W-1:0] : shifted;
        n_data.acc  = {i_data.acc[W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/sdiv4_round.sv
// Rounding adjustment then sign restore, two register stages.
module sdiv4_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sdiv4_pkg::t_stage    i_data,
    output logic                 o_valid,
    output sdiv4_pkg::t_out_item o_item
);
    localparam int W = sdiv4_pkg::DATA_WIDTH;

    logic                 r_rvalid;
    sdiv4_pkg::t_rnd      r_rnd;
    sdiv4_pkg::t_rnd      n_rnd;
    logic                 r_ovalid;
    sdiv4_pkg::t_out_item r_item;
    sdiv4_pkg::t_out_item n_item;
    logic [W:0]           twice;
    logic                 diff_sign;
    logic                 inc;

    // Every adjustment grows the quotient magnitude by one and takes the
    // divisor magnitude off the remainder magnitude.
    always_comb begin
        twice     = {i_data.rem, 1'b0};
        diff_sign = i_data.side.sx ^ i_data.side.sy;
        inc       = 1'b0;
        if (i_data.rem != '0) begin
            unique case (i_data.side.mode)
                sdiv4_pkg::MODE_TRUNC: inc = 1'b0;
                sdiv4_pkg::MODE_FLOOR: inc = diff_sign;
                sdiv4_pkg::MODE_CEIL:  inc = ~diff_sign;
                sdiv4_pkg::MODE_ROUND: inc = (twice > {1'b0, i_data.ay}) ||
                                             ((twice == {1'b0, i_data.ay}) &&
                                              i_data.acc[0]);
                default:               inc = 1'b0;
            endcase
        end
        n_rnd.qm   = i_data.acc + {{(W-1){1'b0}}, inc};
        n_rnd.rm   = inc ? (i_data.rem - i_data.ay) : i_data.rem;
        n_rnd.qneg = diff_sign;
        n_rnd.side = i_data.side;
    end

    always_comb begin
        n_item.divide_by_zero = r_rnd.side.dz;
        n_item.overflow       = r_rnd.side.ovf;
        if (r_rnd.side.dz) begin
            n_item.quotient  = '0;
            n_item.remainder = '0;
        end else begin
            n_item.quotient  = $signed(r_rnd.qneg ? (~r_rnd.qm + 1'b1) : r_rnd.qm);
            n_item.remainder = $signed(r_rnd.side.sx ? (~r_rnd.rm + 1'b1) : r_rnd.rm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (i_en) begin
            r_rvalid <= i_valid;
            r_ovalid <= r_rvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd  <= n_rnd;
            r_item <= n_item;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_item;

endmodule

FILE: design/signed_divide_four_rounding_modes.sv
// Top level: pipelined signed divider with four rounding modes.
//
// Divides a signed dividend by a signed divisor and returns quotient and
// remainder with dividend = quotient*divisor + remainder (modulo 2^32).
// mode selects truncate, floor, ceiling or round to nearest with ties to
// the even quotient (a tie is exactly 2*|r| = |divisor|). A zero divisor
// sets divide_by_zero and gives zero quotient and remainder; the most
// negative dividend over minus one sets overflow, the quotient wraps to
// the most negative value and the remainder is zero.
// Throughput is one item per cycle while the pipeline is not held. It has
// one input stage (magnitudes and flags), a chain of DATA_WIDTH
// restoring-division cells each producing one quotient bit, one rounding
// stage and one output register that applies the signs.
// The whole pipeline moves together; it holds only while a result sits
// in the output register and the downstream side stalls, and o_stall is
// raised in exactly that case. Nothing is kept between items.
module signed_divide_four_rounding_modes (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sdiv4_pkg::t_in_item  i_in_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sdiv4_pkg::t_out_item o_out_item
);
    localparam int W = sdiv4_pkg::DATA_WIDTH;

    logic              en;
    logic              chain_valid [W+1];
    sdiv4_pkg::t_stage chain_data  [W+1];

    // Advance unless a finished item is waiting on a stalled consumer
    assign en      = ~(o_valid & i_stall);
    assign o_stall = ~en;

    sdiv4_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_in_item),
        .o_valid (chain_valid[0]),
        .o_data  (chain_data[0])
    );

    // One cell per quotient bit, most significant first
    for (genvar g = 0; g < W; g++) begin : g_cell
        sdiv4_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    sdiv4_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (chain_valid[W]),
        .i_data  (chain_data[W]),
        .o_valid (o_valid),
        .o_item  (o_out_item)
    );

endmodule
